>>> src/assert_macros.svh
// Assertion macros for the RTL files.
// Depends on: a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: lbl");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: lbl");

`endif

>>> src/aabb_pkg.sv
// Package for the box-pair overlap block: sizes, box type, overlap test.
// No dependencies.
package aabb_pkg;

    localparam int MAX_BOXES    = 64;
    localparam int COORD_BITS   = 24;
    localparam int MARGIN_BITS  = 23;
    localparam int OUT_IDX_BITS = 6;
    localparam int IDX_BITS     = $clog2(MAX_BOXES);
    localparam int CNT_BITS     = $clog2(MAX_BOXES + 1);
    localparam int CMP_BITS     = ((COORD_BITS + 1 > MARGIN_BITS + 1) ?
                                   COORD_BITS + 1 : MARGIN_BITS + 1) + 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [CMP_BITS-1:0]   cmp_t;

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
    } box_t;

    // amin - m <= bmax + m  and  bmin - m <= amax + m, done as a - b <= 2m
    function automatic logic axis_meets(input coord_t amin, input coord_t amax,
                                        input coord_t bmin, input coord_t bmax,
                                        input cmp_t m2);
        cmp_t d0;
        cmp_t d1;
        d0 = CMP_BITS'(amin) - CMP_BITS'(bmax);
        d1 = CMP_BITS'(bmin) - CMP_BITS'(amax);
        return (d0 <= m2) && (d1 <= m2);
    endfunction

    function automatic logic boxes_meet(input box_t a, input box_t b, input cmp_t m2);
        return axis_meets(a.min_x, a.max_x, b.min_x, b.max_x, m2) &&
               axis_meets(a.min_y, a.max_y, b.min_y, b.max_y, m2) &&
               axis_meets(a.min_z, a.max_z, b.min_z, b.max_z, m2);
    endfunction

    function automatic logic [OUT_IDX_BITS-1:0] out_idx(input logic [IDX_BITS-1:0] i);
        logic [IDX_BITS+OUT_IDX_BITS-1:0] w;
        w = {{OUT_IDX_BITS{1'b0}}, i};
        return w[OUT_IDX_BITS-1:0];
    endfunction

endpackage

>>> src/aabb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module aabb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/aabb_all_pairs_overlap_top.sv
// Brute-force box-pair overlap: new box against every stored box of the set.
// Depends on: aabb_pkg, aabb_ram, assert_macros.svh.
//
//  channel   direction  handshake               payload
//  box       in         box_valid/box_ready     start_set, min_*, max_*
//  pair      out        pair_valid/pair_ready   earlier_index, new_index,
//                                                set_full, last_in_run
//  margin    in         margin_we               margin_wdata
//
// With no stall, a box with index N above 0 runs from its accept to the next accept through
// the accept cycle, N RAM reads through the single compare unit, the last compare, the flush.
// Index 0 goes back to idle; a dropped box goes via ST_FULL. box_ready is high only idle.
// A stalled pair beat holds the scan when a second hit or the flush waits behind it.
// Reset (rst_n, async) empties the set and clears the margin; no clearing pass.
`include "assert_macros.svh"

module aabb_all_pairs_overlap_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 margin_we,
    input  logic [aabb_pkg::MARGIN_BITS-1:0]     margin_wdata,
    input  logic                                 box_valid,
    output logic                                 box_ready,
    input  logic                                 start_set,
    input  logic signed [aabb_pkg::COORD_BITS-1:0] min_x,
    input  logic signed [aabb_pkg::COORD_BITS-1:0] min_y,
    input  logic signed [aabb_pkg::COORD_BITS-1:0] min_z,
    input  logic signed [aabb_pkg::COORD_BITS-1:0] max_x,
    input  logic signed [aabb_pkg::COORD_BITS-1:0] max_y,
    input  logic signed [aabb_pkg::COORD_BITS-1:0] max_z,
    output logic                                 pair_valid,
    input  logic                                 pair_ready,
    output logic [aabb_pkg::OUT_IDX_BITS-1:0]    earlier_index,
    output logic [aabb_pkg::OUT_IDX_BITS-1:0]    new_index,
    output logic                                 set_full,
    output logic                                 last_in_run
);
    import aabb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [MARGIN_BITS-1:0] margin_reg;
    box_t                   nb_reg, nb_next;
    logic [IDX_BITS-1:0]    idx_reg, idx_next;
    logic [IDX_BITS-1:0]    issue_reg, issue_next;
    logic                   s1_valid_reg, s1_valid_next;
    logic [IDX_BITS-1:0]    s1_idx_reg, s1_idx_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [IDX_BITS-1:0]    pend_idx_reg, pend_idx_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_IDX_BITS-1:0] out_earlier_reg, out_earlier_next;
    logic [OUT_IDX_BITS-1:0] out_new_reg, out_new_next;
    logic                   out_full_reg, out_full_next;
    logic                   out_last_reg, out_last_next;

    box_t                in_box;
    box_t                rd_box;
    logic                accept;
    logic [CNT_BITS-1:0] acc_cnt;
    logic                acc_full;
    logic                wr_en;
    logic                out_free;
    logic                hit;
    logic                adv;
    logic                issue_more;
    logic                rd_en;
    logic                scan_done;
    cmp_t                m2;

    assign in_box = '{min_x: min_x, min_y: min_y, min_z: min_z,
                      max_x: max_x, max_y: max_y, max_z: max_z};

    assign box_ready  = (state_reg == ST_IDLE);
    assign accept     = box_valid && box_ready;
    assign acc_cnt    = start_set ? '0 : cnt_reg;
    assign acc_full   = (acc_cnt == CNT_BITS'(MAX_BOXES));
    assign wr_en      = accept && !acc_full;
    assign out_free   = !out_valid_reg || pair_ready;
    assign m2         = $signed(CMP_BITS'({margin_reg, 1'b0}));
    assign hit        = s1_valid_reg && boxes_meet(rd_box, nb_reg, m2);
    assign adv        = !(hit && pend_valid_reg) || out_free;
    assign issue_more = (state_reg == ST_SCAN) && (issue_reg != idx_reg);
    assign rd_en      = issue_more && adv;
    assign scan_done  = (state_reg == ST_SCAN) && !issue_more && !s1_valid_reg;

    aabb_ram #(
        .WIDTH ($bits(box_t)),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (acc_cnt[IDX_BITS-1:0]),
        .wdata (in_box),
        .re    (rd_en),
        .raddr (issue_reg),
        .rdata (rd_box)
    );

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        nb_next          = nb_reg;
        idx_next         = idx_reg;
        issue_next       = issue_reg;
        s1_valid_next    = s1_valid_reg;
        s1_idx_next      = s1_idx_reg;
        pend_valid_next  = pend_valid_reg;
        pend_idx_next    = pend_idx_reg;
        out_valid_next   = out_valid_reg && !pair_ready;
        out_earlier_next = out_earlier_reg;
        out_new_next     = out_new_reg;
        out_full_next    = out_full_reg;
        out_last_next    = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    nb_next    = in_box;
                    idx_next   = acc_cnt[IDX_BITS-1:0];
                    issue_next = '0;
                    if (acc_full)
                    begin
                        cnt_next   = acc_cnt;
                        state_next = ST_FULL;
                    end
                    else
                    begin
                        cnt_next = acc_cnt + 1'b1;
                        if (acc_cnt != '0)
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (adv)
                begin
                    s1_valid_next = rd_en;
                    s1_idx_next   = issue_reg;
                    if (rd_en)
                    begin
                        issue_next = issue_reg + 1'b1;
                    end
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next   = 1'b1;
                            out_earlier_next = out_idx(pend_idx_reg);
                            out_new_next     = out_idx(idx_reg);
                            out_full_next    = 1'b0;
                            out_last_next    = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = s1_idx_reg;
                    end
                end
                if (scan_done)
                begin
                    if (!pend_valid_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_next   = 1'b1;
                        out_earlier_next = out_idx(pend_idx_reg);
                        out_new_next     = out_idx(idx_reg);
                        out_full_next    = 1'b0;
                        out_last_next    = 1'b1;
                        pend_valid_next  = 1'b0;
                        state_next       = ST_IDLE;
                    end
                end
            end
            ST_FULL:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_earlier_next = '0;
                    out_new_next     = '0;
                    out_full_next    = 1'b1;
                    out_last_next    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            margin_reg     <= '0;
            s1_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            s1_valid_reg   <= s1_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (margin_we)
            begin
                margin_reg <= margin_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        nb_reg          <= nb_next;
        idx_reg         <= idx_next;
        issue_reg       <= issue_next;
        s1_idx_reg      <= s1_idx_next;
        pend_idx_reg    <= pend_idx_next;
        out_earlier_reg <= out_earlier_next;
        out_new_reg     <= out_new_next;
        out_full_reg    <= out_full_next;
        out_last_reg    <= out_last_next;
    end

    assign pair_valid    = out_valid_reg;
    assign earlier_index = out_earlier_reg;
    assign new_index     = out_new_reg;
    assign set_full      = out_full_reg;
    assign last_in_run   = out_last_reg;

    // checks
    `ASSERT_NEVER(a_cnt_range, cnt_reg > CNT_BITS'(MAX_BOXES))
    `ASSERT_ALWAYS(a_read_below_new, s1_valid_reg |-> (s1_idx_reg < idx_reg))
    `ASSERT_ALWAYS(a_pend_only_scan, pend_valid_reg |-> (state_reg == ST_SCAN))
    `ASSERT_ALWAYS(a_full_beat_shape,
        (out_valid_reg && out_full_reg) |->
            (out_last_reg && (out_earlier_reg == '0) && (out_new_reg == '0)))
    `ASSERT_ALWAYS(a_idle_no_pending,
        (state_reg == ST_IDLE) |-> (!s1_valid_reg && !pend_valid_reg))

endmodule
